@@ rtl/wwc_pkg.sv @@
`timescale 1ns / 1ps

package wwc_pkg;

  // 65-bit machine word
  typedef logic [64:0] word_t;

  // Request actions
  localparam logic [1:0] ACT_EXEC   = 2'd0;
  localparam logic [1:0] ACT_MEM_RD = 2'd1;
  localparam logic [1:0] ACT_REG_RD = 2'd2;

  // Opcodes (bit 7 is instruction bit 64)
  localparam logic [7:0] OP_ADD   = 8'h01;
  localparam logic [7:0] OP_MODE  = 8'h02;
  localparam logic [7:0] OP_LDI   = 8'h03;
  localparam logic [7:0] OP_STORE = 8'h04;
  localparam logic [7:0] OP_JUMP  = 8'h06;
  localparam logic [7:0] OP_BEQZ  = 8'h07;

  // Mode select immediates
  localparam logic [41:0] IMM_NARROW = 42'd31;
  localparam logic [41:0] IMM_WIDE   = 42'd65;

  localparam int NUM_REGS = 32;

  // Register file read request
  typedef struct packed {
    logic       en;
    logic [4:0] addr_a;
    logic [4:0] addr_b;
  } rf_rd_t;

  // Register file write port
  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    word_t      data;
  } rf_wr_t;

  // Narrow mode keeps bits 30..0 only
  function automatic word_t mask_mode(word_t v, logic narrow);
    return narrow ? {34'b0, v[30:0]} : v;
  endfunction

endpackage

@@ rtl/wwc_if.sv @@
`timescale 1ns / 1ps

// Request channel: one instruction or debug read
interface wwc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] word_low;
  logic        word_high;
  logic [11:0] read_index;

  modport source (output valid, action, word_low, word_high, read_index, input ready);
  modport sink   (input valid, action, word_low, word_high, read_index, output ready);
endinterface

// Response channel: one result per request
interface wwc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;
  logic        narrow_mode;
  logic        reg_written;
  logic [4:0]  reg_number;
  logic        mem_written;
  logic [9:0]  mem_address;
  logic [63:0] data_low;
  logic        data_high;

  modport source (output valid, next_pc, narrow_mode, reg_written, reg_number,
                  mem_written, mem_address, data_low, data_high, input ready);
  modport sink   (input valid, next_pc, narrow_mode, reg_written, reg_number,
                  mem_written, mem_address, data_low, data_high, output ready);
endinterface

@@ rtl/wwc_regfile.sv @@
`timescale 1ns / 1ps

module wwc_regfile import wwc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  rf_rd_t rd_i,
  input  rf_wr_t wr_i,
  output word_t  rdata_a_o,
  output word_t  rdata_b_o
);

  word_t               mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;

  word_t ra_q, rb_q, fwd_q;
  logic  va_q, vb_q, hit_a_q, hit_b_q;

  // Storage and registered read data; write data captured for bypass
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      ra_q  <= mem_q[rd_i.addr_a];
      rb_q  <= mem_q[rd_i.addr_b];
      fwd_q <= wr_i.data;
    end
  end

  // Valid bits stand in for the reset clear; same-edge write hit flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        va_q    <= vld_q[rd_i.addr_a];
        vb_q    <= vld_q[rd_i.addr_b];
        hit_a_q <= wr_i.en && (wr_i.addr == rd_i.addr_a);
        hit_b_q <= wr_i.en && (wr_i.addr == rd_i.addr_b);
      end
    end
  end

  // Bypass wins, unwritten entries read zero
  assign rdata_a_o = hit_a_q ? fwd_q : (va_q ? ra_q : '0);
  assign rdata_b_o = hit_b_q ? fwd_q : (vb_q ? rb_q : '0);

endmodule

@@ rtl/wide_word_cpu_execute.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload
// req_i     in   sink     action, word_low, word_high, read_index
// rsp_o     out  source   next_pc, narrow_mode, reg_written, reg_number,
//                         mem_written, mem_address, data_low, data_high
//
// One request per cycle while ready is high. Accept issues the reads; the
// execute stage then executes and writes back into the response register.
// Register file and data memory reads are registered; a write in the same
// cycle as a read is bypassed. After reset the data memory is cleared, one
// word a cycle, with ready low. A stalled response holds the execute
// stage and ready; reads are issued only at accept, so held data stays put.

module wide_word_cpu_execute import wwc_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wwc_req_if.sink   req_i,
  wwc_rsp_if.source rsp_o
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  logic accept, commit;

  // Execute stage
  logic        s1_valid_q;
  logic [1:0]  s1_action_q;
  logic [64:0] s1_word_q;
  logic [11:0] s1_ridx_q;
  logic        s1_mem_ok_q;

  // Architectural state
  logic [63:0] pc_q;
  logic        mode_q;

  // Response register
  logic        rsp_valid_q;
  logic [63:0] rsp_pc_q;
  logic        rsp_mode_q, rsp_rw_q, rsp_mw_q;
  logic [4:0]  rsp_rn_q;
  logic [9:0]  rsp_ma_q;
  word_t       rsp_data_q;

  // Clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // Register file
  rf_rd_t rf_rd;
  rf_wr_t rf_wr;
  word_t  rf_a, rf_b;

  // Data memory
  word_t         dm_q [MEM_WORDS];
  word_t         dm_rdata_q, dm_fwd_q, dm_rd;
  logic          dm_hit_q;
  logic [AW-1:0] dm_raddr, dm_waddr;
  logic          dm_we;
  word_t         dm_wdata;

  // Execute results
  logic [7:0]  op;
  logic [4:0]  dst;
  logic [41:0] imm;
  word_t       sum;
  logic [63:0] pc_n;
  logic        mode_n, rw, mw;
  logic [4:0]  rn;
  logic [9:0]  ma;
  word_t       data;
  logic        st_we;

  // Handshake
  assign commit      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || commit);
  assign accept      = req_i.valid && req_i.ready;

  // Read requests issued at accept
  assign rf_rd.en     = accept;
  assign rf_rd.addr_a = (req_i.action == ACT_REG_RD) ? req_i.read_index[4:0]
                                                     : req_i.word_low[51:47];
  assign rf_rd.addr_b = req_i.word_low[46:42];
  assign dm_raddr     = AW'(req_i.read_index);

  wwc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rf_rd),
    .wr_i      (rf_wr),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  // Data memory write port: clearing pass or store
  assign dm_we    = clr_busy_q || st_we;
  assign dm_waddr = clr_busy_q ? clr_addr_q : imm[AW-1:0];
  assign dm_wdata = clr_busy_q ? '0 : data;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_q[dm_waddr] <= dm_wdata;
    end
    if (accept) begin
      dm_rdata_q <= dm_q[dm_raddr];
      dm_fwd_q   <= dm_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dm_hit_q <= 1'b0;
    end else if (accept) begin
      dm_hit_q <= dm_we && (dm_waddr == dm_raddr);
    end
  end

  assign dm_rd = dm_hit_q ? dm_fwd_q : dm_rdata_q;

  // Clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= req_i.action;
      s1_word_q   <= {req_i.word_high, req_i.word_low};
      s1_ridx_q   <= req_i.read_index;
      s1_mem_ok_q <= 32'(req_i.read_index) < MEM_WORDS;
    end
  end

  // Decode and execute
  assign op  = s1_word_q[64:57];
  assign dst = s1_word_q[56:52];
  assign imm = s1_word_q[41:0];
  assign sum = rf_a + rf_b;

  always_comb begin
    pc_n   = pc_q;
    mode_n = mode_q;
    rw     = 1'b0;
    rn     = '0;
    mw     = 1'b0;
    ma     = '0;
    data   = '0;
    unique case (s1_action_q)
      ACT_EXEC: begin
        pc_n = pc_q + 64'd1;
        unique case (op)
          OP_ADD: begin
            data = mask_mode(sum, mode_q);
            rw   = 1'b1;
            rn   = dst;
          end
          OP_MODE: begin
            if (imm == IMM_NARROW) begin
              mode_n = 1'b1;
            end else if (imm == IMM_WIDE) begin
              mode_n = 1'b0;
            end
          end
          OP_LDI: begin
            data = mask_mode({23'b0, imm}, mode_q);
            rw   = 1'b1;
            rn   = dst;
          end
          OP_STORE: begin
            if (imm < 42'(MEM_WORDS)) begin
              data = mask_mode(rf_a, mode_q);
              mw   = 1'b1;
              ma   = imm[9:0];
            end
          end
          OP_JUMP: begin
            pc_n = {22'b0, imm};
          end
          OP_BEQZ: begin
            if (rf_a == '0) begin
              pc_n = {22'b0, imm};
            end
          end
          default: ;
        endcase
      end
      ACT_MEM_RD: data = s1_mem_ok_q ? dm_rd : '0;
      ACT_REG_RD: data = (s1_ridx_q[11:5] == '0) ? rf_a : '0;
      default: ;
    endcase
  end

  // Write back at commit
  assign rf_wr.en   = commit && rw;
  assign rf_wr.addr = rn;
  assign rf_wr.data = data;
  assign st_we      = commit && mw;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      pc_q        <= '0;
      mode_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
        pc_q        <= pc_n;
        mode_q      <= mode_n;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_pc_q   <= pc_n;
      rsp_mode_q <= mode_n;
      rsp_rw_q   <= rw;
      rsp_rn_q   <= rn;
      rsp_mw_q   <= mw;
      rsp_ma_q   <= ma;
      rsp_data_q <= data;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.next_pc     = rsp_pc_q;
  assign rsp_o.narrow_mode = rsp_mode_q;
  assign rsp_o.reg_written = rsp_rw_q;
  assign rsp_o.reg_number  = rsp_rn_q;
  assign rsp_o.mem_written = rsp_mw_q;
  assign rsp_o.mem_address = rsp_ma_q;
  assign rsp_o.data_low    = rsp_data_q[63:0];
  assign rsp_o.data_high   = rsp_data_q[64];

endmodule

@@ sim/tb_wide_word_cpu_execute.sv @@
`timescale 1ns / 1ps

module tb_wide_word_cpu_execute import wwc_pkg::*; ();

  localparam int          MEM_WORDS   = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_GAP     = 20;
  localparam int unsigned PHASE_ITEMS = 120;

  // Codes the package leaves unnamed
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] OP_FADD  = 8'h05;
  localparam logic [7:0] OP_NOP   = 8'h00;

  // One response as the checker sees it
  typedef struct packed {
    logic [63:0] next_pc;
    logic        narrow;
    logic        reg_wr;
    logic [4:0]  reg_num;
    logic        mem_wr;
    logic [9:0]  mem_addr;
    word_t       data;
  } exec_result_t;

  // Directed stimulus row; fixed holds a hand-written expectation
  typedef struct {
    logic [1:0]   act;
    word_t        instr;
    logic [11:0]  ridx;
    bit           fixed;
    exec_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  wwc_req_if req_if ();
  wwc_rsp_if rsp_if ();

  wide_word_cpu_execute #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Architectural state of the predictor
  word_t       gpr_model  [NUM_REGS]  = '{default: '0};
  word_t       dmem_model [MEM_WORDS] = '{default: '0};
  logic [63:0] pc_model     = '0;
  logic        narrow_model = 1'b0;

  exec_result_t pending_results [$];
  exec_result_t got_res;
  exec_result_t want_res;

  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_off_cycles = 0;

  function automatic exec_result_t make_res(logic [63:0] pc, logic nm, logic rw,
                                            logic [4:0] rn, logic mw, logic [9:0] ma,
                                            word_t d);
    exec_result_t r;
    r.next_pc  = pc;
    r.narrow   = nm;
    r.reg_wr   = rw;
    r.reg_num  = rn;
    r.mem_wr   = mw;
    r.mem_addr = ma;
    r.data     = d;
    return r;
  endfunction

  function automatic word_t encode(logic [7:0] op, logic [4:0] dst, logic [4:0] s1,
                                   logic [4:0] s2, logic [41:0] imm);
    return {op, dst, s1, s2, imm};
  endfunction

  // Written values keep 31 bits in narrow mode
  function automatic word_t fit_to_mode(word_t v);
    return narrow_model ? (v & 65'h7FFF_FFFF) : v;
  endfunction

  // Executes one request on the model state and returns its response
  function automatic exec_result_t execute_request(logic [1:0] act, word_t instr,
                                                   logic [11:0] ridx);
    exec_result_t r;
    logic [7:0]   op;
    logic [4:0]   dst;
    logic [4:0]   s1;
    logic [4:0]   s2;
    logic [41:0]  imm;
    word_t        a;
    word_t        b;
    word_t        v;
    logic         jumped;
    r = '0;
    if (act == ACT_EXEC) begin
      op     = instr[64:57];
      dst    = instr[56:52];
      s1     = instr[51:47];
      s2     = instr[46:42];
      imm    = instr[41:0];
      a      = gpr_model[s1];
      b      = gpr_model[s2];
      jumped = 1'b0;
      case (op)
        OP_ADD: begin
          v = fit_to_mode(a + b);
          gpr_model[dst] = v;
          r.reg_wr  = 1'b1;
          r.reg_num = dst;
          r.data    = v;
        end
        OP_MODE: begin
          if (imm == IMM_NARROW) narrow_model = 1'b1;
          else if (imm == IMM_WIDE) narrow_model = 1'b0;
        end
        OP_LDI: begin
          v = fit_to_mode(word_t'(imm));
          gpr_model[dst] = v;
          r.reg_wr  = 1'b1;
          r.reg_num = dst;
          r.data    = v;
        end
        OP_STORE: begin
          if (imm < MEM_WORDS) begin
            v = fit_to_mode(a);
            dmem_model[imm[9:0]] = v;
            r.mem_wr   = 1'b1;
            r.mem_addr = imm[9:0];
            r.data     = v;
          end
        end
        OP_JUMP: begin
          pc_model = 64'(imm);
          jumped   = 1'b1;
        end
        OP_BEQZ: begin
          if (a == '0) begin
            pc_model = 64'(imm);
            jumped   = 1'b1;
          end
        end
        default: ;
      endcase
      if (!jumped) pc_model = pc_model + 64'd1;
    end else if (act == ACT_MEM_RD) begin
      if (ridx < MEM_WORDS) r.data = dmem_model[ridx[9:0]];
    end else if (act == ACT_REG_RD) begin
      if (ridx < NUM_REGS) r.data = gpr_model[ridx[4:0]];
    end
    r.next_pc = pc_model;
    r.narrow  = narrow_model;
    return r;
  endfunction

  task automatic note_failure(string what, word_t want, word_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Random request: mostly well-formed instructions, some reads, some noise
  task automatic make_random_request(output logic [1:0] act, output word_t instr,
                                     output logic [11:0] ridx);
    int unsigned pick;
    int unsigned w;
    logic [7:0]  op;
    logic [4:0]  dst;
    logic [4:0]  s1;
    logic [4:0]  s2;
    logic [41:0] imm;
    logic [63:0] rnd;
    rnd   = {$urandom, $urandom};
    act   = ACT_EXEC;
    ridx  = 12'($urandom);
    instr = {1'($urandom), rnd};
    pick  = $urandom_range(0, 99);
    if (pick < 6) begin
      act = 2'($urandom);
    end else if (pick < 12) begin
      act = ACT_MEM_RD;
      if ($urandom_range(0, 9) != 0) ridx = 12'($urandom_range(0, 31));
    end else if (pick < 20) begin
      act = ACT_REG_RD;
      if ($urandom_range(0, 9) != 0) ridx = 12'($urandom_range(0, NUM_REGS - 1));
    end else begin
      w   = $urandom_range(0, 42);
      imm = 42'(rnd) & ((42'd1 << w) - 42'd1);
      dst = 5'($urandom);
      s1  = 5'($urandom);
      s2  = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        op = OP_ADD;
        // doubling in a few registers pushes values up to bit 64
        if ($urandom_range(0, 2) == 0) begin
          dst = 5'($urandom_range(0, 7));
          s1  = dst;
          s2  = dst;
        end else if ($urandom_range(0, 1) == 0) begin
          dst = 5'($urandom_range(0, 7));
          s1  = 5'($urandom_range(0, 7));
          s2  = 5'($urandom_range(0, 7));
        end
      end else if (pick < 48) begin
        op = OP_MODE;
        case ($urandom_range(0, 3))
          0:       imm = IMM_NARROW;
          1, 2:    imm = IMM_WIDE;
          default: ;
        endcase
      end else if (pick < 68) begin
        op = OP_LDI;
      end else if (pick < 80) begin
        op = OP_STORE;
        case ($urandom_range(0, 9))
          0:       ;
          1:       imm = 42'($urandom_range(0, MEM_WORDS - 1));
          default: imm = 42'($urandom_range(0, 31));
        endcase
      end else if (pick < 85) begin
        op = OP_JUMP;
      end else if (pick < 95) begin
        op = OP_BEQZ;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_FADD : 8'($urandom);
      end
      instr = encode(op, dst, s1, s2, imm);
    end
  endtask

  // Offers one request, waits for it to be taken, records what it must return
  task automatic send_request(logic [1:0] act, word_t instr, logic [11:0] ridx,
                              bit fixed, exec_result_t fixed_res);
    int unsigned  gap;
    exec_result_t model_res;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.word_low   <= instr[63:0];
    req_if.word_high  <= instr[64];
    req_if.read_index <= ridx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    model_res = execute_request(act, instr, ridx);
    pending_results.push_back(fixed ? fixed_res : model_res);
  endtask

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Response side: random stalls, plus one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        hold_off_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got_res = make_res(rsp_if.next_pc, rsp_if.narrow_mode, rsp_if.reg_written,
                         rsp_if.reg_number, rsp_if.mem_written, rsp_if.mem_address,
                         {rsp_if.data_high, rsp_if.data_low});
      if (pending_results.size() == 0) begin
        note_failure("response with nothing pending", '0, word_t'(got_res.next_pc));
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.next_pc !== want_res.next_pc)
          note_failure("next_pc", word_t'(want_res.next_pc), word_t'(got_res.next_pc));
        if (got_res.narrow !== want_res.narrow)
          note_failure("narrow_mode", word_t'(want_res.narrow), word_t'(got_res.narrow));
        if (got_res.reg_wr !== want_res.reg_wr)
          note_failure("reg_written", word_t'(want_res.reg_wr), word_t'(got_res.reg_wr));
        if (got_res.reg_num !== want_res.reg_num)
          note_failure("reg_number", word_t'(want_res.reg_num), word_t'(got_res.reg_num));
        if (got_res.mem_wr !== want_res.mem_wr)
          note_failure("mem_written", word_t'(want_res.mem_wr), word_t'(got_res.mem_wr));
        if (got_res.mem_addr !== want_res.mem_addr)
          note_failure("mem_address", word_t'(want_res.mem_addr),
                       word_t'(got_res.mem_addr));
        if (got_res.data !== want_res.data)
          note_failure("data", want_res.data, got_res.data);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t   dir_rows [$];
    logic [1:0]  act;
    word_t       instr;
    logic [11:0] ridx;

    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_EXEC;
    req_if.word_low   <= '0;
    req_if.word_high  <= 1'b0;
    req_if.read_index <= '0;

    // reads after reset, reads out of range, unused action
    dir_rows.push_back(stim_row_t'{ACT_REG_RD, '0, 12'd0, 1'b1,
                                   make_res(64'd0, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_MEM_RD, '0, 12'd1023, 1'b1,
                                   make_res(64'd0, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_MEM_RD, '0, 12'hFFF, 1'b1,
                                   make_res(64'd0, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_REG_RD, '0, 12'hFFF, 1'b1,
                                   make_res(64'd0, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_NONE, {65{1'b1}}, 12'hFFF, 1'b1,
                                   make_res(64'd0, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    // load, add, store
    dir_rows.push_back(stim_row_t'{ACT_EXEC,
                                   encode(OP_LDI, 5'd1, 5'd0, 5'd0, 42'h3FF_FFFF_FFFF),
                                   12'd0, 1'b1,
                                   make_res(64'd1, 1'b0, 1'b1, 5'd1, 1'b0, 10'd0,
                                            65'h3FF_FFFF_FFFF)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_LDI, 5'd31, 5'd31, 5'd31, 42'd0),
                                   12'd0, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_ADD, 5'd2, 5'd1, 5'd1, 42'd0),
                                   12'd0, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_ADD, 5'd3, 5'd2, 5'd31, 42'd0),
                                   12'd0, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_STORE, 5'd0, 5'd1, 5'd0, 42'd1023),
                                   12'd0, 1'b0, '0});
    // stores past the end of memory
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_STORE, 5'd0, 5'd1, 5'd0, 42'd1024),
                                   12'd0, 1'b1,
                                   make_res(64'd6, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC,
                                   encode(OP_STORE, 5'd0, 5'd1, 5'd0, 42'h3FF_FFFF_FFFF),
                                   12'd0, 1'b1,
                                   make_res(64'd7, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_MEM_RD, '0, 12'd1023, 1'b0, '0});
    // floating add and unknown opcodes only advance the pc
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_FADD, 5'd1, 5'd1, 5'd1, 42'd0),
                                   12'd0, 1'b1,
                                   make_res(64'd8, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, {65{1'b1}}, 12'd0, 1'b1,
                                   make_res(64'd9, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_NOP, 5'd0, 5'd0, 5'd0, 42'd0),
                                   12'd0, 1'b1,
                                   make_res(64'd10, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC,
                                   encode(OP_ADD | 8'h80, 5'd5, 5'd1, 5'd1, 42'd0),
                                   12'd0, 1'b1,
                                   make_res(64'd11, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    // narrow mode and back
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_MODE, 5'd0, 5'd0, 5'd0, IMM_NARROW),
                                   12'd0, 1'b1,
                                   make_res(64'd12, 1'b1, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC,
                                   encode(OP_LDI, 5'd4, 5'd0, 5'd0, 42'h3FF_FFFF_FFFF),
                                   12'd0, 1'b1,
                                   make_res(64'd13, 1'b1, 1'b1, 5'd4, 1'b0, 10'd0,
                                            65'h7FFF_FFFF)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_MODE, 5'd0, 5'd0, 5'd0, 42'd7),
                                   12'd0, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_MODE, 5'd0, 5'd0, 5'd0, IMM_WIDE),
                                   12'd0, 1'b1,
                                   make_res(64'd15, 1'b0, 1'b0, 5'd0, 1'b0, 10'd0, '0)});
    // branch taken and not taken, jump
    dir_rows.push_back(stim_row_t'{ACT_EXEC,
                                   encode(OP_BEQZ, 5'd0, 5'd31, 5'd0, 42'h3FF_FFFF_FFFF),
                                   12'd0, 1'b1,
                                   make_res(64'h3FF_FFFF_FFFF, 1'b0, 1'b0, 5'd0, 1'b0,
                                            10'd0, '0)});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_BEQZ, 5'd0, 5'd1, 5'd0, 42'd0),
                                   12'd0, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{ACT_EXEC, encode(OP_JUMP, 5'd0, 5'd0, 5'd0, 42'd5),
                                   12'd0, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{ACT_REG_RD, '0, 12'd31, 1'b0, '0});

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].instr, dir_rows[i].ridx,
                   dir_rows[i].fixed, dir_rows[i].want);

    // random phases with different idle patterns; the last one holds off responses
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin
          send_idle_pct   = 0;
          recv_stall_pct  = 0;
          hold_off_cycles = HOLD_CYCLES;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        make_random_request(act, instr, ridx);
        send_request(act, instr, ridx, 1'b0, '0);
      end
    end

    // drain
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_failure("responses still pending", '0, word_t'(pending_results.size()));

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wwc_pkg.sv
rtl/wwc_if.sv
rtl/wwc_regfile.sv
rtl/wide_word_cpu_execute.sv
sim/tb_wide_word_cpu_execute.sv
